@@ hdl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg
// Action and status codes and sequencer states for the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TEST   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_KTH    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_KTH_RD,
    S_KTH_DATA,
    S_FIN
  } state_t;

endpackage

@@ hdl/sorted_set_table_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_set_table_unit
// Bounded sorted set of distinct signed values kept packed in one RAM.
// ----------------------------------------------------------------------------
// Each request takes one action (insert, remove, test, read k-th smallest,
// clear) and yields one result carrying the count after the action. Insert,
// remove and test walk the table once through a single RAM read port and a
// signed less-than and equality compare; the walk may stop early. Insert and
// remove shift entries during the same walk, one write a cycle. Read k-th
// reads the entry at rank - 1 (a rank of zero or above the count is a miss);
// clear empties the table. The unit takes one request at a time; a result
// waits in an output register, so the next request is taken while the
// previous result is still pending.
module sorted_set_table_unit #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [sst_pkg::ACT_W-1:0]               in_action,
  input  logic signed [VALUE_BITS-1:0]            in_key_value,
  input  logic [$clog2(CAPACITY+1)-1:0]           in_rank,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_found,
  output logic signed [VALUE_BITS-1:0]            out_item_value,
  output logic [$clog2(CAPACITY+1)-1:0]           out_entry_count,
  output logic [sst_pkg::STAT_W-1:0]              out_status
);
  import sst_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t                  state_r, state_nxt;
  logic [ACT_W-1:0]        act_r, act_nxt;
  logic signed [VALUE_BITS-1:0] key_r, key_nxt;
  logic [CW-1:0]           rank_r, rank_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic [CW-1:0]           pos_r, pos_nxt;
  logic                    dv_r, dv_nxt;
  logic                    hit_r, hit_nxt;     // insert: key placed; remove: key seen
  logic signed [VALUE_BITS-1:0] hold_r, hold_nxt;
  logic                    res_found_r, res_found_nxt;
  logic signed [VALUE_BITS-1:0] res_item_r, res_item_nxt;
  logic [STAT_W-1:0]       res_status_r, res_status_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;
  logic signed [VALUE_BITS-1:0] out_item_r, out_item_nxt;
  logic [CW-1:0]           out_count_r, out_count_nxt;
  logic [STAT_W-1:0]       out_status_r, out_status_nxt;

  logic signed [VALUE_BITS-1:0] mem [CAPACITY];
  logic signed [VALUE_BITS-1:0] rdata_r;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [VALUE_BITS-1:0] wr_data;

  logic                    is_full;
  logic                    d_lt, d_eq;
  logic [CW-1:0]           pos_m1;
  logic [CW-1:0]           rank_m1;

  assign is_full = (cnt_r == CAP_C);
  assign d_lt    = (rdata_r < key_r);
  assign d_eq    = (rdata_r == key_r);
  assign pos_m1  = pos_r - CW'(1);
  assign rank_m1 = rank_r - CW'(1);

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_item_value  = out_item_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    key_r        <= key_nxt;
    rank_r       <= rank_nxt;
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    hit_r        <= hit_nxt;
    hold_r       <= hold_nxt;
    res_found_r  <= res_found_nxt;
    res_item_r   <= res_item_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_item_r   <= out_item_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    key_nxt        = key_r;
    rank_nxt       = rank_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    dv_nxt         = dv_r;
    hit_nxt        = hit_r;
    hold_nxt       = hold_r;
    res_found_nxt  = res_found_r;
    res_item_nxt   = res_item_r;
    res_status_nxt = res_status_r;
    out_found_nxt  = out_found_r;
    out_item_nxt   = out_item_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    rd_en          = 1'b0;
    rd_addr        = idx_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = pos_r[AW-1:0];
    wr_data        = hold_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          act_nxt        = in_action;
          key_nxt        = in_key_value;
          rank_nxt       = in_rank;
          idx_nxt        = '0;
          dv_nxt         = 1'b0;
          hit_nxt        = 1'b0;
          res_found_nxt  = 1'b0;
          res_item_nxt   = '0;
          res_status_nxt = ST_OK;
          case (in_action)
            ACT_INSERT, ACT_REMOVE, ACT_TEST: begin
              state_nxt = S_SCAN;
            end
            ACT_KTH: begin
              if (in_rank != '0 && in_rank <= cnt_r) begin
                state_nxt = S_KTH_RD;
              end else begin
                res_status_nxt = ST_MISS;
                state_nxt      = S_FIN;
              end
            end
            ACT_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_FIN;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read one entry ahead; rdata_r holds the entry at pos_r when dv_r
        if (idx_r < cnt_r) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + CW'(1);
          pos_nxt = idx_r;
          dv_nxt  = 1'b1;
        end else begin
          dv_nxt = 1'b0;
        end

        if (dv_r) begin
          case (act_r)
            ACT_INSERT: begin
              if (hit_r) begin
                wr_en    = 1'b1;
                wr_data  = hold_r;
                hold_nxt = rdata_r;
              end else if (d_eq) begin
                state_nxt = S_FIN;
              end else if (!d_lt) begin
                if (is_full) begin
                  res_status_nxt = ST_FULL;
                  state_nxt      = S_FIN;
                end else begin
                  wr_en    = 1'b1;
                  wr_data  = key_r;
                  hold_nxt = rdata_r;
                  hit_nxt  = 1'b1;
                end
              end
            end
            ACT_REMOVE: begin
              if (hit_r) begin
                wr_en   = 1'b1;
                wr_addr = pos_m1[AW-1:0];
                wr_data = rdata_r;
              end else if (d_eq) begin
                hit_nxt = 1'b1;
              end else if (!d_lt) begin
                res_status_nxt = ST_MISS;
                state_nxt      = S_FIN;
              end
            end
            default: begin
              if (d_eq) begin
                res_found_nxt = 1'b1;
                state_nxt     = S_FIN;
              end else if (!d_lt) begin
                res_status_nxt = ST_MISS;
                state_nxt      = S_FIN;
              end
            end
          endcase
        end else if (idx_r >= cnt_r) begin
          // walk finished, nothing in flight
          state_nxt = S_FIN;
          case (act_r)
            ACT_INSERT: begin
              if (!hit_r && is_full) begin
                res_status_nxt = ST_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cnt_r[AW-1:0];
                wr_data = hit_r ? hold_r : key_r;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            ACT_REMOVE: begin
              if (hit_r) begin
                res_found_nxt = 1'b1;
                cnt_nxt       = cnt_r - CW'(1);
              end else begin
                res_status_nxt = ST_MISS;
              end
            end
            default: begin
              res_status_nxt = ST_MISS;
            end
          endcase
        end
      end

      S_KTH_RD: begin
        rd_en     = 1'b1;
        rd_addr   = rank_m1[AW-1:0];
        state_nxt = S_KTH_DATA;
      end

      S_KTH_DATA: begin
        res_found_nxt = 1'b1;
        res_item_nxt  = rdata_r;
        state_nxt     = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_item_nxt   = res_item_r;
          out_count_nxt  = cnt_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
